>>> hdl/luhn_pkg.sv
package luhn_pkg;

    localparam int VALUE_W     = 63;
    localparam int MAX_DIGITS  = 19;
    localparam int BCD_DIGITS  = 19;
    localparam int BCD_W       = 4 * BCD_DIGITS;
    localparam int CNT_W       = 5;
    localparam int CONV_BITS   = 7;
    localparam int CONV_STEPS  = VALUE_W / CONV_BITS;
    localparam int STEP_W      = $clog2(CONV_STEPS);

    localparam logic [1:0] CLS_INVALID = 2'd0;
    localparam logic [1:0] CLS_AMEX    = 2'd1;
    localparam logic [1:0] CLS_MC      = 2'd2;
    localparam logic [1:0] CLS_VISA    = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_WALK,
        S_CLASS
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic walk;
        logic classify;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_last;
    } t_dp_sts;

endpackage

>>> hdl/luhn_card_number_classifier.sv
// Channel   Direction  Handshake                    Payload
// card      in         i_card_valid / o_card_ready  i_card_value[62:0]
// result    out        o_res_valid / i_res_ready    o_card_class, o_checksum_ok, o_digit_total
//
// One card at a time: a transfer, a binary-to-BCD conversion (7 bits per step),
// a walk over the decimal digits (1..19), then a classification.
// The digit walk over the BCD register is the part whose length varies.
// A finished result sits in the output register; the next card is taken meanwhile.
// Classification waits while a previous result is still untaken.
// Reset is synchronous, active low, and clears control state only.
module luhn_card_number_classifier (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_card_valid,
    output logic                         o_card_ready,
    input  logic [luhn_pkg::VALUE_W-1:0] i_card_value,
    output logic                         o_res_valid,
    input  logic                         i_res_ready,
    output logic [1:0]                   o_card_class,
    output logic                         o_checksum_ok,
    output logic [luhn_pkg::CNT_W-1:0]   o_digit_total
);
    import luhn_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    luhn_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_card_valid (i_card_valid),
        .o_card_ready (o_card_ready),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_cmd        (w_cmd),
        .i_sts        (w_sts)
    );

    luhn_dp u_dp (
        .i_clk         (i_clk),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_card_value  (i_card_value),
        .o_card_class  (o_card_class),
        .o_checksum_ok (o_checksum_ok),
        .o_digit_total (o_digit_total)
    );

endmodule

>>> hdl/luhn_dp.sv
module luhn_dp (
    input  logic                         i_clk,
    input  luhn_pkg::t_dp_cmd            i_cmd,
    output luhn_pkg::t_dp_sts            o_sts,
    input  logic [luhn_pkg::VALUE_W-1:0] i_card_value,
    output logic [1:0]                   o_card_class,
    output logic                         o_checksum_ok,
    output logic [luhn_pkg::CNT_W-1:0]   o_digit_total
);
    import luhn_pkg::*;

    logic [VALUE_W-1:0] r_bin;
    logic [BCD_W-1:0]   r_bcd;
    logic [3:0]         r_sum;
    logic [CNT_W-1:0]   r_cnt;
    logic [3:0]         r_lead;
    logic [3:0]         r_next;
    logic               r_dbl;
    logic               r_ovf;
    logic [1:0]         r_class;
    logic               r_ok;
    logic [CNT_W-1:0]   r_total;

    logic [BCD_W-1:0]   n_bcd_conv;
    logic [BCD_W-1:0]   n_bcd_walk;
    logic [3:0]         w_digit;
    logic [3:0]         w_term;
    logic [4:0]         w_sum_raw;
    logic [3:0]         n_sum;
    logic [CNT_W-1:0]   n_cnt;
    logic               w_last;
    logic               w_ok;
    logic [1:0]         n_class;

    // one binary bit into the BCD register: add-3 on digits of five or more, then shift
    function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd, input logic b);
        logic [BCD_W-1:0] t;
        t = bcd;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (t[4*k +: 4] >= 4'd5) begin
                t[4*k +: 4] = t[4*k +: 4] + 4'd3;
            end
        end
        return {t[BCD_W-2:0], b};
    endfunction

    always_comb begin
        n_bcd_conv = r_bcd;
        for (int j = 0; j < CONV_BITS; j++) begin
            n_bcd_conv = dabble(n_bcd_conv, r_bin[VALUE_W-1-j]);
        end
    end

    assign w_digit    = r_bcd[3:0];
    assign n_bcd_walk = {4'd0, r_bcd[BCD_W-1:4]};

    always_comb begin
        if (!r_dbl) begin
            w_term = w_digit;
        end else if (w_digit < 4'd5) begin
            w_term = {w_digit[2:0], 1'b0};
        end else begin
            w_term = 4'({w_digit[2:0], 1'b0} - 4'd9);
        end
        w_sum_raw = {1'b0, r_sum} + {1'b0, w_term};
        if (w_sum_raw >= 5'd10) begin
            n_sum = 4'(w_sum_raw - 5'd10);
        end else begin
            n_sum = w_sum_raw[3:0];
        end
    end

    assign n_cnt  = r_cnt + CNT_W'(1);
    assign w_last = (n_bcd_walk == '0) || (n_cnt == CNT_W'(MAX_DIGITS));
    assign o_sts.walk_last = w_last;

    always_comb begin
        w_ok    = (r_sum == 4'd0);
        n_class = CLS_INVALID;
        if (w_ok && !r_ovf) begin
            if (r_cnt == CNT_W'(15) && r_lead == 4'd3 && (r_next == 4'd4 || r_next == 4'd7)) begin
                n_class = CLS_AMEX;
            end else if (r_cnt == CNT_W'(16) && r_lead == 4'd5 && r_next >= 4'd1
                         && r_next <= 4'd5) begin
                n_class = CLS_MC;
            end else if ((r_cnt == CNT_W'(13) || r_cnt == CNT_W'(16)) && r_lead == 4'd4) begin
                n_class = CLS_VISA;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin  <= i_card_value;
            r_bcd  <= '0;
            r_sum  <= 4'd0;
            r_cnt  <= '0;
            r_lead <= 4'd0;
            r_next <= 4'd0;
            r_dbl  <= 1'b0;
            r_ovf  <= 1'b0;
        end
        if (i_cmd.conv) begin
            r_bcd <= n_bcd_conv;
            r_bin <= {r_bin[VALUE_W-1-CONV_BITS:0], CONV_BITS'(0)};
        end
        if (i_cmd.walk) begin
            r_bcd  <= n_bcd_walk;
            r_sum  <= n_sum;
            r_cnt  <= n_cnt;
            r_next <= r_lead;
            r_lead <= w_digit;
            r_dbl  <= !r_dbl;
            r_ovf  <= (n_bcd_walk != '0);
        end
        if (i_cmd.classify) begin
            r_class <= n_class;
            r_ok    <= w_ok;
            r_total <= r_cnt;
        end
    end

    assign o_card_class  = r_class;
    assign o_checksum_ok = r_ok;
    assign o_digit_total = r_total;

endmodule

>>> hdl/luhn_ctrl.sv
module luhn_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_card_valid,
    output logic              o_card_ready,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output luhn_pkg::t_dp_cmd o_cmd,
    input  luhn_pkg::t_dp_sts i_sts
);
    import luhn_pkg::*;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        n_out_valid  = r_out_valid && !i_res_ready;
        o_card_ready = 1'b0;
        o_cmd        = '0;
        case (r_state)
            S_IDLE: begin
                o_card_ready = 1'b1;
                if (i_card_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.conv = 1'b1;
                if (r_step == STEP_W'(CONV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_WALK;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_CLASS;
                end
            end
            S_CLASS: begin
                if (!r_out_valid || i_res_ready) begin
                    o_cmd.classify = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res_valid = r_out_valid;

    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_card_valid && o_card_ready) |=> (r_state == S_CONV))
        else $error("input transfer did not start conversion");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_W'(CONV_STEPS - 1))
        else $error("conversion step counter out of range");

    a_valid_from_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_CLASS))
        else $error("result raised outside classification");

    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && i_sts.walk_last) |=> (r_state == S_CLASS))
        else $error("digit walk did not end on last digit");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.classify) |-> (!r_out_valid || i_res_ready))
        else $error("pending result overwritten");

endmodule
